// File: rtl/core/uedr_pkg.sv
// Shared constants, widths and codes for the ultrasonic echo depth ranger.
`timescale 1ns / 1ps
`default_nettype none

package uedr_pkg;

    // Sequence timing and tick counter
    localparam int COUNTER_BITS       = 20;
    localparam int TRIGGER_LOW_TICKS  = 2;
    localparam int TRIGGER_HIGH_TICKS = 10;

    // Field widths
    localparam int LENGTH_W   = 16;
    localparam int UNIT_W     = 2;
    localparam int SPEED_W    = 20;
    localparam int TIMEOUT_W  = 20;
    localparam int STATUS_W   = 2;
    localparam int DEPTH_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Unit scale factors and arithmetic
    localparam int K_W          = 12;
    localparam int CAP_SHIFT    = 37;
    localparam int ROUND_SHIFT  = 21;
    localparam int MULT_W       = (COUNTER_BITS > K_W) ? COUNTER_BITS : K_W;
    localparam int RAW_PROD_W   = COUNTER_BITS + SPEED_W;
    localparam int SCALED_W     = CAP_SHIFT + 1 + K_W;
    localparam int ACC_W        = (RAW_PROD_W > SCALED_W) ? RAW_PROD_W : SCALED_W;
    localparam int M_W          = ACC_W - ROUND_SHIFT;
    localparam int CMP_W        = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX    = '1;
    localparam logic [ACC_W-1:0]        PROD_CAP   = ACC_W'(1) << CAP_SHIFT;
    localparam logic [ACC_W-1:0]        ROUND_BIAS = ACC_W'(1) << (ROUND_SHIFT - 1);

    localparam logic [K_W-1:0] K_INCH = K_W'(100);
    localparam logic [K_W-1:0] K_CM   = K_W'(254);
    localparam logic [K_W-1:0] K_MM   = K_W'(2540);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL_LENGTH = 2'd0,
        REG_UNIT_SELECT  = 2'd1,
        REG_SOUND_SPEED  = 2'd2,
        REG_ECHO_TIMEOUT = 2'd3
    } cfg_reg_t;

    // Unit codes
    typedef enum logic [UNIT_W-1:0] {
        UNIT_INCH = 2'd0,
        UNIT_CM   = 2'd1,
        UNIT_MM   = 2'd2
    } unit_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 2'd0,
        STS_TIMEOUT_HIGH = 2'd1,
        STS_TIMEOUT_LOW  = 2'd2
    } status_t;

    // Sequencer phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_TLOW  = 9'b000000010,
        PH_THIGH = 9'b000000100,
        PH_WHIGH = 9'b000001000,
        PH_WLOW  = 9'b000010000,
        PH_MUL1  = 9'b000100000,
        PH_MUL2  = 9'b001000000,
        PH_ROUND = 9'b010000000,
        PH_SUB   = 9'b100000000
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/core/uedr_if.sv
// Channel interfaces: tick input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface uedr_in_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic start_request;

    modport source (output valid, output echo_level, output start_request, input ready);
    modport sink   (input valid, input echo_level, input start_request, output ready);
endinterface

interface uedr_out_if import uedr_pkg::*;;
    logic                valid;
    logic                ready;
    logic                trigger_level;
    logic                busy_res;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  depth;

    modport source (output valid, output trigger_level, output busy_res, output result_valid,
                    output status, output depth, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input result_valid,
                    input status, input depth, output ready);
endinterface

interface uedr_cfg_if import uedr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ultrasonic_echo_depth_ranger_unit.sv
// Top level: echo ranging sequencer with shared shift-add depth arithmetic.
//
//  channel | direction | payload
//  req     | in        | echo_level, start_request (one microsecond tick)
//  rsp     | out       | trigger_level, busy_res, result_valid, status, depth
//  cfg     | in        | index, data (register write)
//
// Each tick takes one cycle, but for the tick that ends a good measurement:
// the width * speed and * unit-scale products run on one shared shift-add
// unit, one multiplier bit a cycle, then a round and a subtract, and req is
// not ready meanwhile. Results wait in an output register, so apart from
// that, req stalls only while it is full and not being taken. rst_n clears
// the sequencer and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_depth_ranger_unit
    import uedr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    uedr_in_if.sink     req,
    uedr_out_if.source  rsp,
    uedr_cfg_if.sink    cfg
);

    phase_t                  phase_reg, phase_next;
    logic [COUNTER_BITS-1:0] cnt_reg, cnt_next;

    logic [LENGTH_W-1:0]  total_length_reg;
    logic [UNIT_W-1:0]    unit_select_reg;
    logic [SPEED_W-1:0]   sound_speed_reg;
    logic [TIMEOUT_W-1:0] echo_timeout_reg;

    logic                out_valid_reg, out_valid_next;
    logic                trig_reg, trig_next;
    logic                busy_reg, busy_next;
    logic                rvalid_reg, rvalid_next;
    status_t             status_reg, status_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [MULT_W-1:0] mult_reg, mult_next;

    logic                    calc_active;
    logic                    accept;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    expired;
    logic [ACC_W-1:0]        sum;
    logic [ACC_W-1:0]        capped;
    logic                    last_bit;
    logic [K_W-1:0]          k_sel;
    logic [M_W-1:0]          m_val;
    logic [M_W-1:0]          total_ext;

    assign calc_active = (phase_reg == PH_MUL1) || (phase_reg == PH_MUL2) ||
                         (phase_reg == PH_ROUND) || (phase_reg == PH_SUB);
    assign req.ready   = !calc_active && (!out_valid_reg || rsp.ready);
    assign accept      = req.valid && req.ready;
    assign cfg.ready   = 1'b1;

    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + COUNTER_BITS'(1);
    assign expired = (CMP_W'(cnt_inc) > CMP_W'(echo_timeout_reg)) || (cnt_inc == CNT_MAX);

    // Shared adder of the shift-add unit
    assign sum      = acc_reg + (mult_reg[0] ? mcand_reg : '0);
    assign last_bit = (mult_reg[MULT_W-1:1] == '0);
    assign capped   = (sum > PROD_CAP) ? PROD_CAP : sum;

    assign m_val     = acc_reg[ACC_W-1:ROUND_SHIFT];
    assign total_ext = M_W'(total_length_reg);

    always_comb
    begin
        case (unit_select_reg)
            UNIT_CM: k_sel = K_CM;
            UNIT_MM: k_sel = K_MM;
            default: k_sel = K_INCH;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        trig_next      = trig_reg;
        busy_next      = busy_reg;
        rvalid_next    = rvalid_reg;
        status_next    = status_reg;
        depth_next     = depth_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mult_next      = mult_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            trig_next      = 1'b0;
            busy_next      = 1'b1;
            rvalid_next    = 1'b0;
            status_next    = STS_OK;
            depth_next     = '0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!req.start_request)
                    begin
                        busy_next = 1'b0;
                    end
                    else if (COUNTER_BITS'(1) >= COUNTER_BITS'(TRIGGER_LOW_TICKS))
                    begin
                        phase_next = PH_THIGH;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_TLOW;
                        cnt_next   = COUNTER_BITS'(1);
                    end
                end
                PH_TLOW:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= COUNTER_BITS'(TRIGGER_LOW_TICKS))
                    begin
                        phase_next = PH_THIGH;
                        cnt_next   = '0;
                    end
                end
                PH_THIGH:
                begin
                    trig_next = 1'b1;
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= COUNTER_BITS'(TRIGGER_HIGH_TICKS))
                    begin
                        phase_next = PH_WHIGH;
                        cnt_next   = '0;
                    end
                end
                PH_WHIGH:
                begin
                    if (req.echo_level)
                    begin
                        phase_next = PH_WLOW;
                        cnt_next   = COUNTER_BITS'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (expired)
                        begin
                            rvalid_next = 1'b1;
                            status_next = STS_TIMEOUT_HIGH;
                            phase_next  = PH_IDLE;
                            cnt_next    = '0;
                        end
                    end
                end
                PH_WLOW:
                begin
                    if (!req.echo_level)
                    begin
                        // hold the result back until the depth is worked out
                        rvalid_next    = 1'b1;
                        out_valid_next = 1'b0;
                        acc_next       = '0;
                        mcand_next     = ACC_W'(sound_speed_reg);
                        mult_next      = MULT_W'(cnt_reg);
                        phase_next     = PH_MUL1;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (expired)
                        begin
                            rvalid_next = 1'b1;
                            status_next = STS_TIMEOUT_LOW;
                            phase_next  = PH_IDLE;
                            cnt_next    = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                    busy_next  = 1'b0;
                end
            endcase
        end

        case (phase_reg)
            PH_MUL1:
            begin
                acc_next   = sum;
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                if (last_bit)
                begin
                    // cap the two-way product, then scale to the unit
                    acc_next   = '0;
                    mcand_next = capped;
                    mult_next  = MULT_W'(k_sel);
                    phase_next = PH_MUL2;
                end
            end
            PH_MUL2:
            begin
                acc_next   = sum;
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                if (last_bit)
                begin
                    mcand_next = ROUND_BIAS;
                    mult_next  = MULT_W'(1);
                    phase_next = PH_ROUND;
                end
            end
            PH_ROUND:
            begin
                acc_next   = sum;
                mult_next  = '0;
                phase_next = PH_SUB;
            end
            PH_SUB:
            begin
                depth_next     = (total_ext > m_val) ?
                                 total_length_reg - m_val[DEPTH_W-1:0] : '0;
                out_valid_next = 1'b1;
                phase_next     = PH_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            total_length_reg <= LENGTH_W'(10000);
            unit_select_reg  <= UNIT_INCH;
            sound_speed_reg  <= SPEED_W'(14156);
            echo_timeout_reg <= TIMEOUT_W'(30000);
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TOTAL_LENGTH: total_length_reg <= cfg.data[LENGTH_W-1:0];
                    REG_UNIT_SELECT:  unit_select_reg  <= cfg.data[UNIT_W-1:0];
                    REG_SOUND_SPEED:  sound_speed_reg  <= cfg.data[SPEED_W-1:0];
                    REG_ECHO_TIMEOUT: echo_timeout_reg <= cfg.data[TIMEOUT_W-1:0];
                    default:          total_length_reg <= total_length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        trig_reg   <= trig_next;
        busy_reg   <= busy_next;
        rvalid_reg <= rvalid_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mult_reg   <= mult_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.trigger_level = trig_reg;
    assign rsp.busy_res      = busy_reg;
    assign rsp.result_valid  = rvalid_reg;
    assign rsp.status        = status_reg;
    assign rsp.depth         = depth_reg;

endmodule

`default_nettype wire
